/* rtl/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the two-class priority request queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ID_W            = 16;
    localparam int TAG_W           = 32;

    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_SERVE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             kind;
        logic             high;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

/* rtl/tpq_req_if.sv */
// ----------------------------------------------------------------------------
// tpq_req_if
// Request channel: submit or serve, with class and payload tag.
// ----------------------------------------------------------------------------
interface tpq_req_if import tpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic             high_priority;
    logic [TAG_W-1:0] issue_tag;

    modport source (output valid, output kind, output high_priority, output issue_tag,
                    input ready);
    modport sink   (input valid, input kind, input high_priority, input issue_tag,
                    output ready);
endinterface

/* rtl/tpq_rsp_if.sv */
// ----------------------------------------------------------------------------
// tpq_rsp_if
// Result channel: outcome of one request and the request served next.
// ----------------------------------------------------------------------------
interface tpq_rsp_if import tpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  assigned_id;
    logic [ID_W-1:0]  served_id;
    logic [TAG_W-1:0] served_tag;
    logic             served_high;
    logic             next_valid;
    logic [ID_W-1:0]  next_id;
    logic [TAG_W-1:0] next_tag;
    logic             next_high;

    modport source (output valid, output status, output assigned_id, output served_id,
                    output served_tag, output served_high, output next_valid,
                    output next_id, output next_tag, output next_high, input ready);
    modport sink   (input valid, input status, input assigned_id, input served_id,
                    input served_tag, input served_high, input next_valid,
                    input next_id, input next_tag, input next_high, output ready);
endinterface

/* rtl/two_class_priority_request_queue.sv */
// ----------------------------------------------------------------------------
// two_class_priority_request_queue
// Strict two-class request queue with sequence ids and a next-to-serve view.
//
//   channel  modport  moves
//   req      sink     submit (class, tag) or serve request
//   rsp      source   status, ids, served request, request served next
//
// A submit and an empty serve go from S_IDLE to S_RESP in the back end, a
// serve that removes a request through S_FILL first (registered read of the
// new queue head); the front queue of two requests hides the handshake. No
// clearing pass after reset. A stalled rsp holds the result register and,
// once the front queue fills, drops req.ready.
// ----------------------------------------------------------------------------
module two_class_priority_request_queue import tpq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tpq_req_if.sink    req,
    tpq_rsp_if.source  rsp
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    tpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp       (rsp)
    );

endmodule

/* rtl/tpq_front.sv */
// ----------------------------------------------------------------------------
// tpq_front
// Accepts requests, numbers submits and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module tpq_front import tpq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    tpq_req_if.sink    req,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    cmd_t            q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic [ID_W-1:0] id_reg;
    logic            push;
    logic            pop;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].kind <= req.kind;
            q_reg[wr_ptr_reg].high <= req.high_priority;
            q_reg[wr_ptr_reg].id   <= (req.kind == KIND_SUBMIT) ? id_reg : '0;
            q_reg[wr_ptr_reg].tag  <= req.issue_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            id_reg     <= ID_FIRST;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
                if (req.kind == KIND_SUBMIT)
                begin
                    id_reg <= id_reg + 1'b1;
                end
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/tpq_back.sv */
// ----------------------------------------------------------------------------
// tpq_back
// Carries out requests on the two class queues and drives the result register.
// ----------------------------------------------------------------------------
module tpq_back import tpq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    tpq_rsp_if.source  rsp
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_FILL, S_RESP} state_t;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        return (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    entry_t          mem_hi [QUEUE_DEPTH];
    entry_t          mem_lo [QUEUE_DEPTH];
    entry_t          rd_hi_reg;
    entry_t          rd_lo_reg;

    state_t          state_reg;
    logic [IW-1:0]   head_reg  [2];
    logic [IW-1:0]   tail_reg  [2];
    logic [CW-1:0]   count_reg [2];
    entry_t          cache_reg [2];
    logic            cls_reg;
    status_t         status_reg;
    logic [ID_W-1:0] asg_reg;
    entry_t          srv_reg;
    logic            srv_high_reg;

    logic            out_valid_reg;
    status_t         out_status_reg;
    logic [ID_W-1:0] out_asg_reg;
    entry_t          out_srv_reg;
    logic            out_srv_high_reg;
    logic            out_nv_reg;
    entry_t          out_next_reg;
    logic            out_nh_reg;

    logic            start;
    logic            sub_ok;
    logic            pop_cls;
    logic            pop_any;
    logic            we_hi;
    logic            we_lo;
    logic            re_hi;
    logic            re_lo;
    logic [IW-1:0]   rd_addr;
    entry_t          wr_entry;
    entry_t          fill_entry;

    assign cmd_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign start      = cmd_valid && cmd_ready;
    assign sub_ok     = (count_reg[cmd.high] != CW'(QUEUE_DEPTH));
    assign pop_any    = (count_reg[1] != '0) || (count_reg[0] != '0);
    assign pop_cls    = (count_reg[1] != '0);
    assign wr_entry   = '{id: cmd.id, tag: cmd.tag};
    assign we_hi      = start && (cmd.kind == KIND_SUBMIT) && sub_ok && cmd.high;
    assign we_lo      = start && (cmd.kind == KIND_SUBMIT) && sub_ok && !cmd.high;
    assign re_hi      = start && (cmd.kind == KIND_SERVE) && pop_any && pop_cls;
    assign re_lo      = start && (cmd.kind == KIND_SERVE) && pop_any && !pop_cls;
    assign rd_addr    = idx_inc(head_reg[pop_cls]);
    assign fill_entry = cls_reg ? rd_hi_reg : rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (we_hi)
        begin
            mem_hi[tail_reg[1]] <= wr_entry;
        end
        if (re_hi)
        begin
            rd_hi_reg <= mem_hi[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_lo)
        begin
            mem_lo[tail_reg[0]] <= wr_entry;
        end
        if (re_lo)
        begin
            rd_lo_reg <= mem_lo[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg[0]      <= '0;
            head_reg[1]      <= '0;
            tail_reg[0]      <= '0;
            tail_reg[1]      <= '0;
            count_reg[0]     <= '0;
            count_reg[1]     <= '0;
            cache_reg[0]     <= '0;
            cache_reg[1]     <= '0;
            cls_reg          <= 1'b0;
            status_reg       <= ST_EMPTY;
            asg_reg          <= '0;
            srv_reg          <= '0;
            srv_high_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_EMPTY;
            out_asg_reg      <= '0;
            out_srv_reg      <= '0;
            out_srv_high_reg <= 1'b0;
            out_nv_reg       <= 1'b0;
            out_next_reg     <= '0;
            out_nh_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        srv_reg      <= '0;
                        srv_high_reg <= 1'b0;
                        asg_reg      <= cmd.id;
                        state_reg    <= S_RESP;
                        if (cmd.kind == KIND_SUBMIT)
                        begin
                            if (sub_ok)
                            begin
                                status_reg           <= ST_ACCEPTED;
                                tail_reg[cmd.high]   <= idx_inc(tail_reg[cmd.high]);
                                count_reg[cmd.high]  <= count_reg[cmd.high] + 1'b1;
                                if (count_reg[cmd.high] == '0)
                                begin
                                    cache_reg[cmd.high] <= wr_entry;
                                end
                            end
                            else
                            begin
                                status_reg <= ST_DROPPED;
                            end
                        end
                        else if (pop_any)
                        begin
                            status_reg         <= ST_SERVED;
                            srv_reg            <= cache_reg[pop_cls];
                            srv_high_reg       <= pop_cls;
                            head_reg[pop_cls]  <= rd_addr;
                            count_reg[pop_cls] <= count_reg[pop_cls] - 1'b1;
                            cls_reg            <= pop_cls;
                            state_reg          <= S_FILL;
                        end
                        else
                        begin
                            status_reg <= ST_EMPTY;
                        end
                    end
                end
                S_FILL:
                begin
                    if (count_reg[cls_reg] != '0)
                    begin
                        cache_reg[cls_reg] <= fill_entry;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    out_valid_reg    <= 1'b1;
                    out_status_reg   <= status_reg;
                    out_asg_reg      <= asg_reg;
                    out_srv_reg      <= srv_reg;
                    out_srv_high_reg <= srv_high_reg;
                    priority if (count_reg[1] != '0)
                    begin
                        out_nv_reg   <= 1'b1;
                        out_next_reg <= cache_reg[1];
                        out_nh_reg   <= 1'b1;
                    end
                    else if (count_reg[0] != '0)
                    begin
                        out_nv_reg   <= 1'b1;
                        out_next_reg <= cache_reg[0];
                        out_nh_reg   <= 1'b0;
                    end
                    else
                    begin
                        out_nv_reg   <= 1'b0;
                        out_next_reg <= '0;
                        out_nh_reg   <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.assigned_id = out_asg_reg;
    assign rsp.served_id   = out_srv_reg.id;
    assign rsp.served_tag  = out_srv_reg.tag;
    assign rsp.served_high = out_srv_high_reg;
    assign rsp.next_valid  = out_nv_reg;
    assign rsp.next_id     = out_next_reg.id;
    assign rsp.next_tag    = out_next_reg.tag;
    assign rsp.next_high   = out_nh_reg;

endmodule
